// ===== rtl/core/sfd_pkg.sv =====
// sfd_pkg: shared types and constants for the sensor frame deframer
// no dependencies; imported by the parser, the output stage, the top level and the checker

package sfd_pkg;

  // frame delimiters and register reset value
  localparam logic [7:0]  START_BYTE       = 8'h3A;
  localparam logic [7:0]  END_BYTE0        = 8'h0D;
  localparam logic [7:0]  END_BYTE1        = 8'h0A;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

  // result kind codes
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_ABORT   = 2'd2;

  // parser phase
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_ADDR0   = 4'd1,
    PH_ADDR1   = 4'd2,
    PH_CMD0    = 4'd3,
    PH_CMD1    = 4'd4,
    PH_LEN0    = 4'd5,
    PH_LEN1    = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_CS0     = 4'd8,
    PH_CS1     = 4'd9,
    PH_END0    = 4'd10,
    PH_END1    = 4'd11
  } phase_t;

  // one result from the parser to the output register
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_address;
    logic [15:0] frame_command;
    logic [15:0] frame_length;
    logic        checksum_ok;
  } result_t;

endpackage

// ===== rtl/core/sfd_in_stage.sv =====
// sfd_in_stage: input register holding one received byte
// no package dependencies; instantiated by sensor_frame_deframer_core

module sfd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       load;

  // hold off the sender while the held byte is not consumed
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // byte register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// ===== rtl/core/sfd_parser.sv =====
// sfd_parser: frame phase machine, header registers and running checksum
// depends on sfd_pkg for phase_t, result_t and the frame constants

module sfd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           max_length,
  output sfd_pkg::result_t      res
);
  import sfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] rsum_r, rsum_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] len_full;
  logic [16:0] count_inc;
  logic [15:0] sum_add;

  assign len_full  = {rx_byte, len_r[7:0]};
  assign count_inc = {1'b0, count_r} + 17'd1;
  assign sum_add   = sum_r + {8'd0, rx_byte};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_ADDR0:   phase_nxt = PH_ADDR1;
      PH_ADDR1:   phase_nxt = PH_CMD0;
      PH_CMD0:    phase_nxt = PH_CMD1;
      PH_CMD1:    phase_nxt = PH_LEN0;
      PH_LEN0:    phase_nxt = PH_LEN1;
      PH_LEN1: begin
        if (len_full > max_length) begin
          phase_nxt = PH_HUNT;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CS0;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (count_inc >= {1'b0, len_r}) begin
          phase_nxt = PH_CS0;
        end
      end
      PH_CS0:     phase_nxt = PH_CS1;
      PH_CS1:     phase_nxt = PH_END0;
      PH_END0:    phase_nxt = (rx_byte == END_BYTE0) ? PH_END1 : PH_HUNT;
      PH_END1:    phase_nxt = PH_HUNT;
      default:    phase_nxt = (rx_byte == START_BYTE) ? PH_ADDR0 : PH_HUNT;
    endcase
  end

  // field registers, sums and result
  always_comb begin
    addr_nxt      = addr_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    rsum_nxt      = rsum_r;
    count_nxt     = count_r;
    res.valid     = 1'b0;
    res.kind      = KIND_PAYLOAD;
    res.data_byte = 8'd0;
    res.checksum_ok = 1'b0;
    unique case (phase_r)
      PH_ADDR0: begin
        addr_nxt = {8'd0, rx_byte};
        sum_nxt  = sum_add;
      end
      PH_ADDR1: begin
        addr_nxt = {rx_byte, addr_r[7:0]};
        sum_nxt  = sum_add;
      end
      PH_CMD0: begin
        cmd_nxt = {8'd0, rx_byte};
        sum_nxt = sum_add;
      end
      PH_CMD1: begin
        cmd_nxt = {rx_byte, cmd_r[7:0]};
        sum_nxt = sum_add;
      end
      PH_LEN0: begin
        len_nxt = {8'd0, rx_byte};
        sum_nxt = sum_add;
      end
      PH_LEN1: begin
        len_nxt = len_full;
        sum_nxt = sum_add;
        if (len_full > max_length) begin
          res.valid = 1'b1;
          res.kind  = KIND_ABORT;
        end else if (len_full != 16'd0) begin
          count_nxt = 16'd0;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt       = sum_add;
        count_nxt     = count_inc[15:0];
        res.valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = rx_byte;
      end
      PH_CS0: begin
        rsum_nxt = {8'd0, rx_byte};
      end
      PH_CS1: begin
        rsum_nxt = {rx_byte, rsum_r[7:0]};
      end
      PH_END0: begin
        if (rx_byte != END_BYTE0) begin
          res.valid = 1'b1;
          res.kind  = KIND_ABORT;
        end
      end
      PH_END1: begin
        res.valid = 1'b1;
        if (rx_byte == END_BYTE1) begin
          res.kind        = KIND_ACCEPT;
          res.checksum_ok = (sum_r == rsum_r);
        end else begin
          res.kind = KIND_ABORT;
        end
      end
      default: begin
        // start byte clears the frame context
        if (rx_byte == START_BYTE) begin
          addr_nxt  = 16'd0;
          cmd_nxt   = 16'd0;
          len_nxt   = 16'd0;
          sum_nxt   = 16'd0;
          rsum_nxt  = 16'd0;
          count_nxt = 16'd0;
        end
      end
    endcase
    res.frame_address = addr_nxt;
    res.frame_command = cmd_nxt;
    res.frame_length  = len_nxt;
  end

  // state registers, updated once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      addr_r  <= 16'd0;
      cmd_r   <= 16'd0;
      len_r   <= 16'd0;
      sum_r   <= 16'd0;
      rsum_r  <= 16'd0;
      count_r <= 16'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      rsum_r  <= rsum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/sfd_out_stage.sv =====
// sfd_out_stage: result register driving the output channel
// depends on sfd_pkg for result_t

module sfd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  sfd_pkg::result_t      res,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_data_byte,
  output logic [15:0]           out_frame_address,
  output logic [15:0]           out_frame_command,
  output logic [15:0]           out_frame_length,
  output logic                  out_checksum_ok
);
  import sfd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // register is free when empty or when its content is transferred now
  assign can_load = !valid_r || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= fire && res.valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (can_load && fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = res_r.kind;
  assign out_data_byte     = res_r.data_byte;
  assign out_frame_address = res_r.frame_address;
  assign out_frame_command = res_r.frame_command;
  assign out_frame_length  = res_r.frame_length;
  assign out_checksum_ok   = res_r.checksum_ok;

endmodule

// ===== rtl/core/sensor_frame_deframer_core.sv =====
// sensor_frame_deframer_core: top level of the byte-serial frame deframer
// depends on sfd_pkg, sfd_in_stage, sfd_parser and sfd_out_stage
//
// Usage:
//   in_valid / in_stall / in_rx_byte carry one received link byte per transfer.
//   out_valid / out_stall carry one result per transfer: a payload byte, a
//   frame accept (header fields and checksum_ok) or a frame abort.
//   cfg_valid / cfg_ready / cfg_max_length write the largest accepted payload
//   length; cfg_ready is always high, writes belong only to idle periods.
// Flow: a transferred byte is held in the input register, parsed when the result
//   register is free, and its result, if any, is registered there for transfer.
// Throughput: one byte per cycle while the receiver does not stall; the parser is a
//   single registered pass from the input register to the result register, its phase
//   and sums updated once per consumed byte.
// Reset (synchronous, rst_n low): both stage registers empty, parser hunting
//   for the start byte, header fields and sums cleared, max_length 4096.
// Receiver stall: the result register holds; the held input byte then
//   waits and in_stall rises, so no byte is lost or dropped.

module sensor_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_frame_address,
  output logic [15:0] out_frame_command,
  output logic [15:0] out_frame_length,
  output logic        out_checksum_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_length
);
  import sfd_pkg::*;

  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        can_load;
  logic        fire;
  logic [15:0] max_length_r;
  result_t     res;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_max_length;
    end
  end

  // parse a byte whenever one is held and the result register is free
  assign fire = byte_valid && can_load;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (fire),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  sfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .rx_byte    (byte_data),
    .max_length (max_length_r),
    .res        (res)
  );

  sfd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire              (fire),
    .res               (res),
    .can_load          (can_load),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_frame_address (out_frame_address),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .out_checksum_ok   (out_checksum_ok)
  );

endmodule

// ===== rtl/core/sfd_checker.sv =====
// sfd_checker: port-level assertions for sensor_frame_deframer_core
// depends on sfd_pkg for the kind codes; bound to the top level below

module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic        out_checksum_ok
);
  import sfd_pkg::*;

  // no result right after a reset cycle
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_data_byte) && $stable(out_checksum_ok))
    else $error("stalled result changed");

  // only defined kind codes leave the block
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_PAYLOAD || out_kind == KIND_ACCEPT
      || out_kind == KIND_ABORT))
    else $error("undefined result kind");

  // data byte is zero outside payload results
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_data_byte == 8'd0)
    else $error("data byte set on non-payload result");

  // checksum flag only on accept
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ACCEPT |-> !out_checksum_ok)
    else $error("checksum flag set on non-accept result");

endmodule

bind sensor_frame_deframer_core sfd_checker u_sfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_data_byte   (out_data_byte),
  .out_checksum_ok (out_checksum_ok)
);

// ===== dv/sensor_frame_deframer_core_tb.sv =====
// sensor_frame_deframer_core_tb: self-checking bench for the byte-serial frame deframer
// depends on sfd_pkg and sensor_frame_deframer_core; a frame tracker predicts every
// payload, accept and abort result and checks them in order against the dut
`timescale 1ns / 100ps

module sensor_frame_deframer_core_tb;
  import sfd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 1550;
  localparam int NUM_SETTINGS  = 7;
  localparam int MAX_GAP       = 9;

  // frame tracker: parser state copy plus the queue of results still due
  class frame_tracker;
    result_t     due_results[$];
    logic [15:0] max_len;
    phase_t      phase;
    logic [15:0] addr;
    logic [15:0] cmd;
    logic [15:0] len;
    logic [15:0] run_sum;
    logic [15:0] rx_sum;
    logic [15:0] count;
    int          errors;

    function new();
      max_len = MAX_LENGTH_RESET;
      phase   = PH_HUNT;
      addr    = '0;
      cmd     = '0;
      len     = '0;
      run_sum = '0;
      rx_sum  = '0;
      count   = '0;
      errors  = 0;
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] data, logic ok);
      result_t r;
      r.valid         = 1'b1;
      r.kind          = kind;
      r.data_byte     = data;
      r.frame_address = addr;
      r.frame_command = cmd;
      r.frame_length  = len;
      r.checksum_ok   = ok;
      due_results = {due_results, r};
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [16:0] next_count;
      case (phase)
        PH_ADDR0: begin
          addr    = {8'h00, b};
          run_sum = run_sum + {8'h00, b};
          phase   = PH_ADDR1;
        end
        PH_ADDR1: begin
          addr[15:8] = b;
          run_sum    = run_sum + {8'h00, b};
          phase      = PH_CMD0;
        end
        PH_CMD0: begin
          cmd     = {8'h00, b};
          run_sum = run_sum + {8'h00, b};
          phase   = PH_CMD1;
        end
        PH_CMD1: begin
          cmd[15:8] = b;
          run_sum   = run_sum + {8'h00, b};
          phase     = PH_LEN0;
        end
        PH_LEN0: begin
          len     = {8'h00, b};
          run_sum = run_sum + {8'h00, b};
          phase   = PH_LEN1;
        end
        PH_LEN1: begin
          len[15:8] = b;
          run_sum   = run_sum + {8'h00, b};
          if (len > max_len) begin
            push_result(KIND_ABORT, 8'h00, 1'b0);
            phase = PH_HUNT;
          end else if (len == 16'd0) begin
            phase = PH_CS0;
          end else begin
            count = '0;
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          next_count = {1'b0, count} + 17'd1;
          run_sum    = run_sum + {8'h00, b};
          push_result(KIND_PAYLOAD, b, 1'b0);
          count = next_count[15:0];
          if (next_count >= {1'b0, len}) phase = PH_CS0;
        end
        PH_CS0: begin
          rx_sum = {8'h00, b};
          phase  = PH_CS1;
        end
        PH_CS1: begin
          rx_sum[15:8] = b;
          phase        = PH_END0;
        end
        PH_END0: begin
          if (b == END_BYTE0) begin
            phase = PH_END1;
          end else begin
            push_result(KIND_ABORT, 8'h00, 1'b0);
            phase = PH_HUNT;
          end
        end
        PH_END1: begin
          if (b == END_BYTE1) push_result(KIND_ACCEPT, 8'h00, run_sum == rx_sum);
          else push_result(KIND_ABORT, 8'h00, 1'b0);
          phase = PH_HUNT;
        end
        default: begin
          // hunting, and any unused phase code behaves the same
          if (b == START_BYTE) begin
            addr    = '0;
            cmd     = '0;
            len     = '0;
            run_sum = '0;
            rx_sum  = '0;
            count   = '0;
            phase   = PH_ADDR0;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
      end
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual kind %0d", $time, got.kind);
        return;
      end
      want = due_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(got.kind));
      check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      check_field("frame_address", want.frame_address, got.frame_address);
      check_field("frame_command", want.frame_command, got.frame_command);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_frame_address;
  logic [15:0] out_frame_command;
  logic [15:0] out_frame_length;
  logic        out_checksum_ok;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_length;

  frame_tracker tracker;
  logic [15:0]  cur_max_length;
  int           frame_bytes;
  int           in_gap_max;
  int           out_gap_max;

  always #HALF_PERIOD clk = ~clk;

  sensor_frame_deframer_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_frame_address (out_frame_address),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .out_checksum_ok   (out_checksum_ok),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_length    (cfg_max_length)
  );

  // monitor both channels at every edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        got.valid         = 1'b1;
        got.kind          = out_kind;
        got.data_byte     = out_data_byte;
        got.frame_address = out_frame_address;
        got.frame_command = out_frame_command;
        got.frame_length  = out_frame_length;
        got.checksum_ok   = out_checksum_ok;
        tracker.check_result(got);
      end
    end
  end

  // result side stall: a random hold-off before each result transfer
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = $urandom_range(0, out_gap_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sensor_frame_deframer_core_tb NOT OK");
    $finish;
  end

  // one byte transfer after a random gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // build a frame with random payload; sum_flip spoils the checksum, cut truncates
  task automatic send_frame(input logic [15:0] addr, input logic [15:0] cmd,
                            input logic [15:0] len, input logic [15:0] sum_flip,
                            input logic [7:0] end0, input logic [7:0] end1, input int cut);
    logic [7:0]  bytes_q[$];
    logic [7:0]  b;
    logic [15:0] sum;
    int          limit;
    bytes_q = '{START_BYTE, addr[7:0], addr[15:8], cmd[7:0], cmd[15:8], len[7:0], len[15:8]};
    sum = '0;
    for (int i = 1; i < 7; i++) sum = sum + {8'h00, bytes_q[i]};
    for (int i = 0; i < int'(len) && (cut == 0 || bytes_q.size() < cut); i++) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum + {8'h00, b};
      bytes_q = {bytes_q, b};
    end
    sum = sum ^ sum_flip;
    bytes_q = {bytes_q, sum[7:0], sum[15:8], end0, end1};
    limit = (cut > 0 && cut < bytes_q.size()) ? cut : bytes_q.size();
    for (int i = 0; i < limit; i++) send_byte(bytes_q[i]);
    frame_bytes += limit;
  endtask

  // wait until the block is drained and quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] value);
    cfg_valid      <= 1'b1;
    cfg_max_length <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid       <= 1'b0;
    cur_max_length   = value;
    tracker.max_len  = value;
  endtask

  // mostly well formed frames, with noise, oversize, bad sums, bad ends and cuts
  task automatic random_frame();
    int          sel;
    int          len_cap;
    logic [15:0] len;
    logic [15:0] flip;
    logic [7:0]  e0;
    logic [7:0]  e1;
    int          cut;
    sel         = $urandom_range(0, 99);
    in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
    flip        = '0;
    e0          = END_BYTE0;
    e1          = END_BYTE1;
    cut         = 0;
    len_cap     = (cur_max_length < 16'd12) ? int'(cur_max_length) : 12;
    if ($urandom_range(0, 19) == 0 && cur_max_length >= 16'd40) len_cap = 40;
    len = 16'($urandom_range(0, len_cap));
    if (sel < 6) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end else if (sel < 16 && cur_max_length != 16'hFFFF) begin
      len = 16'($urandom_range(int'(cur_max_length) + 1, 65535));
      cut = 7;
    end else if (sel < 30) begin
      flip = 16'($urandom_range(1, 65535));
    end else if (sel < 36) begin
      e0 = 8'($urandom_range(0, 255));
      if (e0 == END_BYTE0) e0 = ~e0;
    end else if (sel < 42) begin
      e1 = 8'($urandom_range(0, 255));
      if (e1 == END_BYTE1) e1 = ~e1;
    end else if (sel < 48) begin
      cut = $urandom_range(1, 10 + int'(len));
    end
    send_frame(16'($urandom), 16'($urandom), len, flip, e0, e1, cut);
  endtask

  // main sequence
  initial begin
    logic [15:0] settings[NUM_SETTINGS];
    int          phase_start;
    tracker         = new();
    cur_max_length  = MAX_LENGTH_RESET;
    frame_bytes     = 0;
    in_gap_max      = MAX_GAP;
    out_gap_max     = MAX_GAP;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_rx_byte     <= 8'h00;
    cfg_valid      <= 1'b0;
    cfg_max_length <= 16'h0000;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: noise while hunting, oversize under the reset limit, zero length,
    // checksum mismatch, wrong first end byte, wrong second end byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'hFFFF, 16'h0000, MAX_LENGTH_RESET + 16'd1, '0, END_BYTE0, END_BYTE1, 7);
    send_frame(16'h0000, 16'hFFFF, 16'd0, '0, END_BYTE0, END_BYTE1, 0);
    send_frame(16'hA55A, 16'h5AA5, 16'd1, 16'h0001, END_BYTE0, END_BYTE1, 0);
    send_frame(16'h1234, 16'h8001, 16'd0, '0, END_BYTE1, END_BYTE1, 0);
    send_frame(16'h0001, 16'h7FFE, 16'd0, '0, END_BYTE0, END_BYTE0, 0);
    settle();

    // random phases over several length limits, extremes included
    settings = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 12)), MAX_LENGTH_RESET,
                 16'($urandom_range(0, 65535)), 16'd5};
    foreach (settings[k]) begin
      write_max_length(settings[k]);
      phase_start = frame_bytes;
      while (frame_bytes - phase_start < RANDOM_BYTES / NUM_SETTINGS) random_frame();
      settle();
    end

    if (tracker.errors == 0) begin
      $display("sensor_frame_deframer_core_tb OK");
    end else begin
      $display("sensor_frame_deframer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
